// ===== rtl/hbbc_pkg.sv =====
// Shared types and constants of the hashed block buffer cache directory.
package hbbc_pkg;

  localparam int NUM_ENTRIES_DEF = 32;
  localparam int NUM_BUCKETS_DEF = 13;
  localparam int BKT_W = 4;
  localparam int BKT_MAX = 16;
  localparam logic [7:0] REF_MAX = 8'hFF;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_RELEASE = 2'd1,
    FN_PIN     = 2'd2,
    FN_UNPIN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_PICK,
    S_FETCH,
    S_WB
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic fetch;
    logic wb;
  } dp_cmd_t;

  typedef struct packed {
    logic is_get;
    logic mod_done;
    logic scan_done;
    logic need_pass2;
  } dp_sts_t;

  typedef struct packed {
    logic [7:0]       dev;
    logic [31:0]      blk;
    logic [7:0]       refc;
    logic [31:0]      lut;
    logic [BKT_W-1:0] hb;
    logic [31:0]      io;
    logic             cv;
  } entry_t;

endpackage

// ===== rtl/hbbc_ctrl.sv =====
// Sequencing state machine of the buffer cache directory.
module hbbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output hbbc_pkg::dp_cmd_t cmd,
  input  hbbc_pkg::dp_sts_t sts
);
  import hbbc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = sts.is_get ? S_MOD : S_FETCH;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        if (sts.need_pass2) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hbbc_dp.sv =====
// Datapath of the buffer cache directory: entry memory, bucket hash, scan and update.
module hbbc_dp #(
  parameter int NUM_ENTRIES = hbbc_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_BUCKETS = hbbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hbbc_pkg::dp_cmd_t cmd,
  output hbbc_pkg::dp_sts_t sts,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_device_id,
  input  logic [31:0]       in_block_number,
  input  logic [4:0]        in_buffer_index,
  input  logic [31:0]       in_now,
  output logic              out_valid,
  output logic [4:0]        out_entry_index,
  output logic              out_hit,
  output logic              out_need_read,
  output logic [1:0]        out_status
);
  import hbbc_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [BKT_W:0] NB = (BKT_W + 1)'(NUM_BUCKETS);

  entry_t mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_r;
  entry_t rd_q;
  logic [IW-1:0] raddr, raddr_q;
  entry_t ent;

  func_t fn_r;
  logic [7:0] dev_r;
  logic [31:0] blk_r, now_r, ord_r;
  logic [4:0] bi_r;
  logic bad_r;

  logic [31:0] sh_r;
  logic [BKT_W:0] rem_r, rem_nxt;
  logic [2:0] mcnt_r;
  logic [BKT_W-1:0] home;

  logic [CW-1:0] cnt_r;
  logic pv_r, pass_r;
  logic [BKT_W-1:0] steal_r, steal_nxt, vsel;
  logic [BKT_MAX-1:0] mask_r, other;
  logic hit_f_r, vf_r;
  logic [IW-1:0] hit_idx_r, vidx_r, tgt_r;
  logic [31:0] hit_io_r, vlut_r, vio_r;
  logic found_r, is_hit_r, stolen_r;

  logic match, elig, better_hit, better_vic;
  logic wr_en;
  entry_t wr_word;
  logic [4:0] o_entry;
  logic o_hit, o_nr;
  status_t o_st;

  logic out_valid_r, out_hit_r, out_nr_r;
  logic [4:0] out_entry_r;
  status_t out_st_r;

  assign home = rem_r[BKT_W-1:0];
  assign vsel = pass_r ? steal_r : home;
  assign raddr = cmd.fetch ? tgt_r : cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
    raddr_q <= raddr;
    if (cmd.wb && wr_en) begin
      mem[tgt_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wb && wr_en) begin
      vld_r[tgt_r] <= 1'b1;
    end
  end

  always_comb begin
    if (vld_r[raddr_q]) begin
      ent = rd_q;
    end else begin
      ent = '0;
      ent.io = 32'(raddr_q);
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    for (int k = 0; k < 4; k++) begin
      rem_nxt = {rem_nxt[BKT_W-1:0], sh_r[31 - k]};
      if (rem_nxt >= NB) begin
        rem_nxt = rem_nxt - NB;
      end
    end
  end

  always_comb begin
    other = mask_r;
    other[home] = 1'b0;
    steal_nxt = '0;
    for (int b = BKT_MAX - 1; b >= 0; b--) begin
      if (other[b]) begin
        steal_nxt = BKT_W'(b);
      end
    end
  end

  assign match = (ent.hb == home) && (ent.dev == dev_r) && (ent.blk == blk_r);
  assign elig = (ent.hb == vsel) && (ent.refc == 8'd0);
  assign better_hit = !hit_f_r || (ent.io > hit_io_r);
  assign better_vic = !vf_r || (ent.lut < vlut_r) || ((ent.lut == vlut_r) && (ent.io < vio_r));

  assign sts.is_get = (in_func == FN_GET);
  assign sts.mod_done = (mcnt_r == 3'd7);
  assign sts.scan_done = (cnt_r == CW'(NUM_ENTRIES)) && !pv_r;
  assign sts.need_pass2 = !pass_r && !hit_f_r && !vf_r && (|other);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= 32'(NUM_ENTRIES);
      out_valid_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wb;
      if (cmd.scan_start) begin
        pv_r <= 1'b0;
      end else begin
        pv_r <= cmd.scan_step && (cnt_r != CW'(NUM_ENTRIES));
      end
      if (cmd.wb && (fn_r == FN_GET) && found_r && !is_hit_r && stolen_r) begin
        ord_r <= ord_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r <= func_t'(in_func);
      dev_r <= in_device_id;
      blk_r <= in_block_number;
      now_r <= in_now;
      bi_r <= in_buffer_index;
      bad_r <= (32'(in_buffer_index) >= 32'(NUM_ENTRIES));
      tgt_r <= IW'(in_buffer_index);
      sh_r <= in_block_number;
      rem_r <= '0;
      mcnt_r <= '0;
    end
    if (cmd.mod_step) begin
      rem_r <= rem_nxt;
      sh_r <= {sh_r[27:0], 4'd0};
      mcnt_r <= mcnt_r + 3'd1;
    end
    if (cmd.scan_start) begin
      cnt_r <= '0;
      vf_r <= 1'b0;
      if (cmd.pick) begin
        pass_r <= 1'b1;
        steal_r <= steal_nxt;
      end else begin
        pass_r <= 1'b0;
        hit_f_r <= 1'b0;
        mask_r <= '0;
      end
    end else begin
      if (cmd.scan_step && (cnt_r != CW'(NUM_ENTRIES))) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (pv_r) begin
        if (match && better_hit && !pass_r) begin
          hit_f_r <= 1'b1;
          hit_idx_r <= raddr_q;
          hit_io_r <= ent.io;
        end
        if (elig && better_vic) begin
          vf_r <= 1'b1;
          vidx_r <= raddr_q;
          vlut_r <= ent.lut;
          vio_r <= ent.io;
        end
        if (!pass_r && (ent.refc == 8'd0)) begin
          mask_r[ent.hb] <= 1'b1;
        end
      end
      if (cmd.pick) begin
        found_r <= hit_f_r || vf_r;
        is_hit_r <= hit_f_r;
        stolen_r <= pass_r;
        tgt_r <= hit_f_r ? hit_idx_r : vidx_r;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_word = ent;
    o_entry = bi_r;
    o_hit = 1'b0;
    o_nr = 1'b0;
    o_st = ST_OK;
    if (fn_r == FN_GET) begin
      if (!found_r) begin
        o_st = ST_NONE;
        o_entry = '0;
      end else begin
        o_entry = 5'(tgt_r);
        wr_en = 1'b1;
        wr_word.cv = 1'b1;
        if (is_hit_r) begin
          o_hit = 1'b1;
          o_nr = !ent.cv;
          if (ent.refc == REF_MAX) begin
            o_st = ST_ERR;
          end else begin
            wr_word.refc = ent.refc + 8'd1;
          end
        end else begin
          o_nr = 1'b1;
          wr_word.dev = dev_r;
          wr_word.blk = blk_r;
          wr_word.refc = 8'd1;
          if (stolen_r) begin
            wr_word.hb = home;
            wr_word.io = ord_r;
          end
        end
      end
    end else if (bad_r) begin
      o_st = ST_ERR;
    end else if (fn_r == FN_PIN) begin
      if (ent.refc == REF_MAX) begin
        o_st = ST_ERR;
      end else begin
        wr_en = 1'b1;
        wr_word.refc = ent.refc + 8'd1;
      end
    end else if (ent.refc == 8'd0) begin
      o_st = ST_ERR;
    end else begin
      wr_en = 1'b1;
      wr_word.refc = ent.refc - 8'd1;
      if ((fn_r == FN_RELEASE) && (ent.refc == 8'd1)) begin
        wr_word.lut = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_entry_r <= o_entry;
      out_hit_r <= o_hit;
      out_nr_r <= o_nr;
      out_st_r <= o_st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_entry_index = out_entry_r;
  assign out_hit = out_hit_r;
  assign out_need_read = out_nr_r;
  assign out_status = out_st_r;

endmodule

// ===== rtl/hashed_block_buffer_cache_unit.sv =====
// Top level of the hashed block buffer cache tag directory.
// A transaction is accepted at a clock edge where start is high and busy is low.
// in_func selects get, release, pin or unpin; get uses in_device_id and
// in_block_number, the others use in_buffer_index, and release stores in_now.
// Every transaction yields one result, shown for exactly one cycle with
// out_valid high; the receiver cannot stall it, so it must take it then.
// Release, pin and unpin pass from acceptance through the fetch and
// write-back states to the result strobe. A get hashes the block number four
// bits per cycle, then scans the entry memory one entry per cycle through its
// single read port; when there is no hit, the home bucket has no free entry
// and another bucket has one, a second scan picks the entry to move over.
// busy stays high until the result strobe, so one transaction is in work at a
// time. Reset clears the state machine, the output strobe, the order counter
// and the per-entry valid bits, so every entry reads as its reset value until
// first written; no clearing pass is needed.
module hashed_block_buffer_cache_unit #(
  parameter int NUM_ENTRIES = hbbc_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_BUCKETS = hbbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_device_id,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_index,
  input  logic [31:0] in_now,
  output logic        out_valid,
  output logic [4:0]  out_entry_index,
  output logic        out_hit,
  output logic        out_need_read,
  output logic [1:0]  out_status
);
  import hbbc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hbbc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  hbbc_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_device_id    (in_device_id),
    .in_block_number (in_block_number),
    .in_buffer_index (in_buffer_index),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_entry_index (out_entry_index),
    .out_hit         (out_hit),
    .out_need_read   (out_need_read),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/hbbc_checker.sv =====
// Port-level checks of the buffer cache directory and their binding.
module hbbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [4:0]  out_entry_index,
  input logic        out_hit,
  input logic        out_need_read,
  input logic [1:0]  out_status
);
  import hbbc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy did not rise after a transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy)) else $error("result outside end of work");

  a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NONE)) |->
      ((out_entry_index == 5'd0) && !out_hit && !out_need_read))
    else $error("failed get returned entry fields");

  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status != ST_NONE))
    else $error("hit reported with no entry");

endmodule

bind hashed_block_buffer_cache_unit hbbc_checker u_hbbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_entry_index (out_entry_index),
  .out_hit         (out_hit),
  .out_need_read   (out_need_read),
  .out_status      (out_status)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the hashed block buffer cache tag directory.
`timescale 1ns / 100ps

module testbench;
  import hbbc_pkg::*;

  localparam int ENTRIES = 32;
  localparam int BUCKETS = 13;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [4:0] entry;
    logic       hit;
    logic       need_read;
    status_t    status;
  } lookup_result_t;

  class cache_scoreboard;
    logic [7:0]  dev_tag[ENTRIES];
    logic [31:0] blk_tag[ENTRIES];
    logic [7:0]  refs[ENTRIES];
    logic [31:0] last_use[ENTRIES];
    int          bucket_of[ENTRIES];
    logic [31:0] age[ENTRIES];
    bit          loaded[ENTRIES];
    logic [31:0] age_counter;
    lookup_result_t expected_q[$];
    int errors, gets, hits, nones, faults, checked;

    function new();
      for (int e = 0; e < ENTRIES; e++) begin
        dev_tag[e] = 0;
        blk_tag[e] = 0;
        refs[e] = 0;
        last_use[e] = 0;
        bucket_of[e] = 0;
        age[e] = e;
        loaded[e] = 0;
      end
      age_counter = ENTRIES;
    endfunction

    function int lru_free(int b);
      int best;
      best = -1;
      for (int e = 0; e < ENTRIES; e++) begin
        if (bucket_of[e] == b && refs[e] == 0) begin
          if (best < 0 || last_use[e] < last_use[best] ||
              (last_use[e] == last_use[best] && age[e] < age[best]))
            best = e;
        end
      end
      return best;
    endfunction

    function void note_request(func_t f, logic [7:0] dev, logic [31:0] blk,
                               logic [4:0] idx, logic [31:0] now);
      lookup_result_t r;
      int home, e;
      r = '{entry: 0, hit: 0, need_read: 0, status: ST_OK};
      if (f == FN_GET) begin
        gets++;
        home = int'(blk % BUCKETS);
        e = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (bucket_of[i] == home && dev_tag[i] == dev && blk_tag[i] == blk)
            if (e < 0 || age[i] > age[e]) e = i;
        end
        if (e >= 0) begin
          r.hit = 1'b1;
          hits++;
          if (refs[e] == REF_MAX) r.status = ST_ERR;
          else refs[e]++;
        end else begin
          e = lru_free(home);
          for (int b = 0; b < BUCKETS && e < 0; b++)
            if (b != home) begin
              e = lru_free(b);
              if (e >= 0) begin
                bucket_of[e] = home;
                age[e] = age_counter;
                age_counter++;
              end
            end
          if (e >= 0) begin
            dev_tag[e] = dev;
            blk_tag[e] = blk;
            loaded[e] = 0;
            refs[e] = 8'd1;
          end else begin
            r.status = ST_NONE;
            nones++;
          end
        end
        if (e >= 0) begin
          r.entry = 5'(e);
          r.need_read = !loaded[e];
          loaded[e] = 1;
        end
      end else begin
        r.entry = idx;
        if (f == FN_PIN) begin
          if (refs[idx] == REF_MAX) r.status = ST_ERR;
          else refs[idx]++;
        end else if (refs[idx] == 0) begin
          r.status = ST_ERR;
        end else begin
          refs[idx]--;
          if (f == FN_RELEASE && refs[idx] == 0) last_use[idx] = now;
        end
      end
      if (r.status == ST_ERR) faults++;
      expected_q.push_back(r);
    endfunction

    function void check_result(lookup_result_t act);
      lookup_result_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result entry=%0d hit=%0d need_read=%0d status=%0d",
                 $time, act.entry, act.hit, act.need_read, act.status);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (act.entry !== exp.entry) begin
        $display("%0t: entry_index expected %0d actual %0d", $time, exp.entry, act.entry);
        errors++;
      end
      if (act.hit !== exp.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, exp.hit, act.hit);
        errors++;
      end
      if (act.need_read !== exp.need_read) begin
        $display("%0t: need_read expected %0d actual %0d", $time,
                 exp.need_read, act.need_read);
        errors++;
      end
      if (act.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [7:0]  in_device_id;
  logic [31:0] in_block_number;
  logic [4:0]  in_buffer_index;
  logic [31:0] in_now;
  logic        out_valid;
  logic [4:0]  out_entry_index;
  logic        out_hit;
  logic        out_need_read;
  logic [1:0]  out_status;

  cache_scoreboard sb;
  int idle_cycles;
  logic [31:0] tick;

  hashed_block_buffer_cache_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_device_id(in_device_id), .in_block_number(in_block_number),
    .in_buffer_index(in_buffer_index), .in_now(in_now),
    .out_valid(out_valid), .out_entry_index(out_entry_index), .out_hit(out_hit),
    .out_need_read(out_need_read), .out_status(out_status)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid)
        sb.check_result('{entry: out_entry_index, hit: out_hit,
                          need_read: out_need_read, status: status_t'(out_status)});
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [4:0] held_entry();
    int base;
    base = $urandom_range(0, ENTRIES - 1);
    for (int i = 0; i < ENTRIES; i++)
      if (sb.refs[(base + i) % ENTRIES] != 0) return 5'((base + i) % ENTRIES);
    return 5'(base);
  endfunction

  function automatic logic [31:0] next_now();
    if ($urandom_range(0, 19) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, 5);
    return tick;
  endfunction

  task automatic issue(func_t f, logic [7:0] dev, logic [31:0] blk,
                       logic [4:0] idx, logic [31:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_device_id <= dev;
    in_block_number <= blk;
    in_buffer_index <= idx;
    in_now <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(f, dev, blk, idx, now);
  endtask

  task automatic get_block(logic [7:0] dev, logic [31:0] blk);
    issue(FN_GET, dev, blk, 5'($urandom), next_now());
  endtask

  task automatic handle_op(func_t f, logic [4:0] idx, logic [31:0] now);
    issue(f, 8'($urandom), $urandom, idx, now);
  endtask

  task automatic fill_and_drain();
    for (int e = 0; e < ENTRIES; e++)
      if (sb.refs[e] == 0) handle_op(FN_PIN, 5'(e), next_now());
    get_block(8'($urandom), $urandom);
    for (int e = 0; e < ENTRIES; e++)
      if ($urandom_range(0, 1)) handle_op(FN_UNPIN, 5'(e), next_now());
      else handle_op(FN_RELEASE, 5'(e), next_now());
  endtask

  task automatic saturate_entry();
    logic [4:0] e;
    e = 5'($urandom_range(0, ENTRIES - 1));
    while (sb.refs[e] != REF_MAX) handle_op(FN_PIN, e, next_now());
    handle_op(FN_PIN, e, next_now());
    get_block(sb.dev_tag[e], sb.blk_tag[e]);
    while (sb.refs[e] != 0) handle_op(FN_RELEASE, e, next_now());
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      get_block($urandom_range(0, 9) < 7 ? 8'($urandom_range(0, 3)) : 8'($urandom),
                $urandom_range(0, 9) < 7 ? 32'($urandom_range(0, 39)) : $urandom);
    else if (r < 80)
      handle_op(FN_RELEASE, $urandom_range(0, 9) < 8 ? held_entry() : 5'($urandom),
                next_now());
    else if (r < 90)
      handle_op(FN_PIN, 5'($urandom), next_now());
    else
      handle_op(FN_UNPIN, $urandom_range(0, 9) < 7 ? held_entry() : 5'($urandom),
                next_now());
  endtask

  initial begin
    int waited;
    sb = new();
    tick = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= FN_GET;
    in_device_id <= '0;
    in_block_number <= '0;
    in_buffer_index <= '0;
    in_now <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: cold hit, misses, steals, counter limits and time extremes.
    issue(FN_GET, 8'h00, 32'h0, 5'h00, 32'h0);
    issue(FN_GET, 8'h00, 32'h0, 5'h1F, 32'hFFFF_FFFF);
    issue(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'h00, 32'hFFFF_FFFF);
    issue(FN_GET, 8'h00, 32'd13, 5'h00, 32'd1);
    issue(FN_GET, 8'h01, 32'd1, 5'h00, 32'd2);
    issue(FN_GET, 8'h01, 32'd1, 5'h00, 32'd3);
    issue(FN_RELEASE, 8'h00, 32'h0, 5'd31, 32'hFFFF_FFFF);
    issue(FN_RELEASE, 8'h00, 32'h0, 5'd31, 32'd5);
    issue(FN_RELEASE, 8'h00, 32'h0, 5'd31, 32'd6);
    issue(FN_UNPIN, 8'h00, 32'h0, 5'd0, 32'd7);
    issue(FN_UNPIN, 8'h00, 32'h0, 5'd5, 32'd8);
    issue(FN_PIN, 8'h00, 32'h0, 5'd5, 32'd9);
    issue(FN_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd5, 32'hFFFF_FFFF);
    issue(FN_PIN, 8'h00, 32'h0, 5'd0, 32'd0);
    issue(FN_RELEASE, 8'h00, 32'h0, 5'd0, 32'd0);
    issue(FN_GET, 8'h02, 32'd26, 5'h00, 32'd10);
    issue(FN_GET, 8'h03, 32'hFFFF_FFF0, 5'h00, 32'd11);
    issue(FN_RELEASE, 8'h00, 32'h0, held_entry(), 32'hAAAA_5555);
    issue(FN_RELEASE, 8'h00, 32'h0, held_entry(), 32'h5555_AAAA);

    for (int i = 0; i < 200; i++) random_item();
    fill_and_drain();
    saturate_entry();
    for (int i = 0; i < 200; i++) random_item();
    fill_and_drain();
    for (int i = 0; i < 40; i++) random_item();

    start <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (120) @(posedge clk);

    $display("Checked %0d transactions: %0d gets, %0d hits, %0d with no free entry,",
             sb.checked, sb.gets, sb.hits, sb.nones);
    $display("%0d count or handle faults, %0d mismatches.", sb.faults, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
